// ===== design/qte_pkg.sv =====
// Package: shared widths and the arctangent table for the quaternion to Euler angle unit.
`timescale 1ns / 1ps
`default_nettype none
package qte_pkg;
    localparam int ANGLE_ITERATIONS_DEF = 16;
    localparam int ATAN_TAB_LEN         = 24;
    localparam int CW                   = 38;  // CORDIC x/y datapath width
    localparam int AW                   = 25;  // angle accumulator, 2^-15 degree
    localparam int TW                   = 34;  // sine / cosine terms, 2^-30 units
    localparam int ROLL_LIMIT           = 23040;
    localparam int PITCH_LIMIT          = 11520;

    // atan(2^-i) in degrees times 32768, rounded
    function automatic logic signed [AW-1:0] atan_tab(input int i);
        logic signed [AW-1:0] r;
        unique case (i)
            0:  r = AW'(1474560);
            1:  r = AW'(870484);
            2:  r = AW'(459940);
            3:  r = AW'(233473);
            4:  r = AW'(117189);
            5:  r = AW'(58652);
            6:  r = AW'(29333);
            7:  r = AW'(14667);
            8:  r = AW'(7334);
            9:  r = AW'(3667);
            10: r = AW'(1833);
            11: r = AW'(917);
            12: r = AW'(458);
            13: r = AW'(229);
            14: r = AW'(115);
            15: r = AW'(57);
            16: r = AW'(29);
            17: r = AW'(14);
            18: r = AW'(7);
            19: r = AW'(4);
            20: r = AW'(2);
            21: r = AW'(1);
            default: r = '0;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

// ===== design/qte_cordic.sv =====
// Pipelined vectoring CORDIC: atan2(y, x) in 1/128 degree, clamped to +-LIMIT.
`timescale 1ns / 1ps
`default_nettype none
module qte_cordic
    import qte_pkg::*;
#(
    parameter int ITER  = ANGLE_ITERATIONS_DEF,
    parameter int LIMIT = ROLL_LIMIT
)(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 vld_in,
    input  wire logic signed [CW-1:0] y_in,
    input  wire logic signed [CW-1:0] x_in,
    output logic                      vld_out,
    output logic signed [15:0]        angle
);
    localparam int NI = (ITER > ATAN_TAB_LEN) ? ATAN_TAB_LEN : ITER;
    localparam logic signed [AW-1:0] DEG90 = AW'(90 * 32768);
    localparam logic signed [AW-1:0] LIM_P = AW'(LIMIT);
    localparam logic signed [AW-1:0] LIM_N = -AW'(LIMIT);

    logic signed [CW-1:0] x_reg [0:NI];
    logic signed [CW-1:0] y_reg [0:NI];
    logic signed [AW-1:0] a_reg [0:NI];
    logic                 z_reg [0:NI];
    logic                 v_reg [0:NI];
    logic                 vld_out_reg;
    logic signed [15:0]   angle_reg;

    // quadrant pre-rotation
    logic signed [CW-1:0] x_pre, y_pre;
    logic signed [AW-1:0] a_pre;
    always_comb
    begin
        x_pre = x_in;
        y_pre = y_in;
        a_pre = '0;
        if (x_in < 0)
        begin
            if (y_in >= 0)
            begin
                x_pre = y_in;
                y_pre = -x_in;
                a_pre = DEG90;
            end
            else
            begin
                x_pre = -y_in;
                y_pre = x_in;
                a_pre = -DEG90;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else
            v_reg[0] <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        x_reg[0] <= x_pre;
        y_reg[0] <= y_pre;
        a_reg[0] <= a_pre;
        z_reg[0] <= (x_in == 0) && (y_in == 0);
    end

    for (genvar i = 0; i < NI; i++)
    begin : g_iter
        logic signed [CW-1:0] dx, dy, x_next, y_next;
        logic signed [AW-1:0] a_next;
        always_comb
        begin
            dx = y_reg[i] >>> i;
            dy = x_reg[i] >>> i;
            if (y_reg[i] > 0)
            begin
                x_next = x_reg[i] + dx;
                y_next = y_reg[i] - dy;
                a_next = a_reg[i] + atan_tab(i);
            end
            else
            begin
                x_next = x_reg[i] - dx;
                y_next = y_reg[i] + dy;
                a_next = a_reg[i] - atan_tab(i);
            end
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i+1] <= 1'b0;
            else
                v_reg[i+1] <= v_reg[i];
        end
        always_ff @(posedge clk)
        begin
            x_reg[i+1] <= x_next;
            y_reg[i+1] <= y_next;
            a_reg[i+1] <= a_next;
            z_reg[i+1] <= z_reg[i];
        end
    end

    // round half up to 1/128 degree, then clamp
    logic signed [AW-1:0] rnd;
    logic signed [15:0]   angle_next;
    always_comb
    begin
        rnd = (a_reg[NI] + AW'(128)) >>> 8;
        if (z_reg[NI])
            angle_next = '0;
        else if (rnd > LIM_P)
            angle_next = 16'(LIMIT);
        else if (rnd < LIM_N)
            angle_next = -16'(LIMIT);
        else
            angle_next = rnd[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_out_reg <= 1'b0;
        else
            vld_out_reg <= v_reg[NI];
    end

    always_ff @(posedge clk)
    begin
        angle_reg <= angle_next;
    end

    assign vld_out = vld_out_reg;
    assign angle   = angle_reg;

    a_zero_angle: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[NI] && z_reg[NI] |=> angle == 16'sd0)
        else $error("zero vector gave nonzero angle");
    a_limit: assert property (@(posedge clk) disable iff (!rst_n)
        vld_out |-> (angle <= 16'(LIMIT)) && (angle >= -16'(LIMIT)))
        else $error("angle out of range");
    a_valid_flow: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[NI] |=> vld_out)
        else $error("result lost at output stage");
endmodule
`default_nettype wire

// ===== design/quaternion_to_euler_angles_unit.sv =====
// Top level: unit quaternion (Q1.15) to ZYX roll, pitch and yaw in 1/128 degree.
//
// Usage:
//   Drive quat_w/x/y/z and raise start; a request is taken at each rising edge
//   with start high and busy low. busy is never raised: a new request can be
//   taken in every cycle.
//   Each request yields one result: done is high for exactly one cycle with
//   roll_angle, pitch_angle, yaw_angle and pitch_clamped valid in that cycle.
//   N = min(ANGLE_ITERATIONS, 24) is the CORDIC iteration count.
//   Throughput is one request per cycle. The pipeline is set by four front
//   stages (products, terms, pitch sine magnitude, square), a 31-stage
//   bit-per-stage square root for the pitch cosine, and N+2 CORDIC stages
//   (pre-rotation, one micro-rotation each, rounding) run in parallel for
//   roll, pitch and yaw.
//   Pitch saturates to +-90 degrees with pitch_clamped set when the sine
//   term reaches magnitude one; the input is not renormalized.
//   Reset clears all valid bits; requests in flight are dropped. The
//   receiver cannot stall, so results leave on the fixed schedule.
`timescale 1ns / 1ps
`default_nettype none
module quaternion_to_euler_angles_unit
    import qte_pkg::*;
#(
    parameter int ANGLE_ITERATIONS = ANGLE_ITERATIONS_DEF
)(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [15:0] quat_w,
    input  wire logic signed [15:0] quat_x,
    input  wire logic signed [15:0] quat_y,
    input  wire logic signed [15:0] quat_z,
    output logic                    done,
    output logic signed [15:0]      roll_angle,
    output logic signed [14:0]      pitch_angle,
    output logic signed [15:0]      yaw_angle,
    output logic                    pitch_clamped
);
    localparam int NI       = (ANGLE_ITERATIONS > ATAN_TAB_LEN) ? ATAN_TAB_LEN
                                                                : ANGLE_ITERATIONS;
    localparam int SQ_STEPS = 31;
    localparam int CLAT     = NI + 2;
    localparam int LAT      = 4 + SQ_STEPS + CLAT;
    localparam logic signed [TW-1:0] ONE_Q30 = TW'(64'sd1 <<< 30);

    typedef struct packed {
        logic signed [TW-1:0] sr;
        logic signed [TW-1:0] cr;
        logic signed [TW-1:0] sy;
        logic signed [TW-1:0] cy;
        logic signed [TW-1:0] sp;
        logic                 cl_pos;
        logic                 cl_neg;
    } terms_t;

    typedef struct packed {
        logic cl_pos;
        logic cl_neg;
    } clamp_t;

    assign busy = 1'b0;
    logic accept;
    assign accept = start && !busy;

    // stage 1: component products, exact in 2^-30 units
    logic signed [31:0] wx_reg, yz_reg, wz_reg, xy_reg, wy_reg, zx_reg;
    logic signed [31:0] xx_reg, yy_reg, zz_reg;
    logic               v1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        wx_reg <= quat_w * quat_x;
        yz_reg <= quat_y * quat_z;
        wz_reg <= quat_w * quat_z;
        xy_reg <= quat_x * quat_y;
        wy_reg <= quat_w * quat_y;
        zx_reg <= quat_z * quat_x;
        xx_reg <= quat_x * quat_x;
        yy_reg <= quat_y * quat_y;
        zz_reg <= quat_z * quat_z;
    end

    // stage 2: sine and cosine terms
    terms_t t_next, t2_reg;
    logic   v2_reg;
    always_comb
    begin
        t_next.sr = (TW'(wx_reg) + TW'(yz_reg)) <<< 1;
        t_next.cr = ONE_Q30 - ((TW'(xx_reg) + TW'(yy_reg)) <<< 1);
        t_next.sy = (TW'(wz_reg) + TW'(xy_reg)) <<< 1;
        t_next.cy = ONE_Q30 - ((TW'(yy_reg) + TW'(zz_reg)) <<< 1);
        t_next.sp = (TW'(wy_reg) - TW'(zx_reg)) <<< 1;
        t_next.cl_pos = 1'b0;
        t_next.cl_neg = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        t2_reg <= t_next;
    end

    // stage 3: saturation test and pitch sine magnitude
    terms_t      t3_next, t3_reg;
    logic [29:0] mag_next, mag_reg;
    logic signed [TW-1:0] sp_abs;
    logic        v3_reg;
    always_comb
    begin
        t3_next        = t2_reg;
        t3_next.cl_pos = t2_reg.sp >= ONE_Q30;
        t3_next.cl_neg = t2_reg.sp <= -ONE_Q30;
        sp_abs         = (t2_reg.sp < 0) ? -t2_reg.sp : t2_reg.sp;
        mag_next       = sp_abs[29:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        t3_reg  <= t3_next;
        mag_reg <= mag_next;
    end

    // stage 4 and square root pipeline: c = floor(sqrt(2^60 - s^2))
    logic [61:0] sv_reg [0:SQ_STEPS];
    logic [61:0] sr_reg [0:SQ_STEPS];
    terms_t      td_reg [0:SQ_STEPS];
    logic        sq_v_reg [0:SQ_STEPS];
    logic [59:0] sq_prod;

    assign sq_prod = 60'(mag_reg) * 60'(mag_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_v_reg[0] <= 1'b0;
        else
            sq_v_reg[0] <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        sv_reg[0] <= (62'd1 << 60) - 62'(sq_prod);
        sr_reg[0] <= '0;
        td_reg[0] <= t3_reg;
    end

    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_sqrt
        localparam logic [61:0] BIT = 62'd1 << (60 - 2 * k);
        logic [61:0] trial, v_next, r_next;
        always_comb
        begin
            trial = sr_reg[k] + BIT;
            if (sv_reg[k] >= trial)
            begin
                v_next = sv_reg[k] - trial;
                r_next = (sr_reg[k] >> 1) + BIT;
            end
            else
            begin
                v_next = sv_reg[k];
                r_next = sr_reg[k] >> 1;
            end
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_v_reg[k+1] <= 1'b0;
            else
                sq_v_reg[k+1] <= sq_v_reg[k];
        end
        always_ff @(posedge clk)
        begin
            sv_reg[k+1] <= v_next;
            sr_reg[k+1] <= r_next;
            td_reg[k+1] <= td_reg[k];
        end
    end

    // three CORDIC pipelines in lockstep
    terms_t               tf;
    logic signed [CW-1:0] pitch_x;
    assign tf      = td_reg[SQ_STEPS];
    assign pitch_x = CW'(signed'({1'b0, sr_reg[SQ_STEPS][30:0]}));

    logic               roll_vld, pitch_vld, yaw_vld;
    logic signed [15:0] pitch_raw;

    qte_cordic #(.ITER(ANGLE_ITERATIONS), .LIMIT(ROLL_LIMIT)) u_roll (
        .clk(clk), .rst_n(rst_n), .vld_in(sq_v_reg[SQ_STEPS]),
        .y_in(CW'(tf.sr)), .x_in(CW'(tf.cr)),
        .vld_out(roll_vld), .angle(roll_angle)
    );

    qte_cordic #(.ITER(ANGLE_ITERATIONS), .LIMIT(PITCH_LIMIT)) u_pitch (
        .clk(clk), .rst_n(rst_n), .vld_in(sq_v_reg[SQ_STEPS]),
        .y_in(CW'(tf.sp)), .x_in(pitch_x),
        .vld_out(pitch_vld), .angle(pitch_raw)
    );

    qte_cordic #(.ITER(ANGLE_ITERATIONS), .LIMIT(ROLL_LIMIT)) u_yaw (
        .clk(clk), .rst_n(rst_n), .vld_in(sq_v_reg[SQ_STEPS]),
        .y_in(CW'(tf.sy)), .x_in(CW'(tf.cy)),
        .vld_out(yaw_vld), .angle(yaw_angle)
    );

    // saturation flags ride alongside the CORDIC stages
    clamp_t cd_reg [0:CLAT];
    assign cd_reg[0] = '{cl_pos: tf.cl_pos, cl_neg: tf.cl_neg};
    for (genvar j = 0; j < CLAT; j++)
    begin : g_cdel
        always_ff @(posedge clk)
        begin
            cd_reg[j+1] <= cd_reg[j];
        end
    end

    always_comb
    begin
        priority if (cd_reg[CLAT].cl_pos)
            pitch_angle = 15'(PITCH_LIMIT);
        else if (cd_reg[CLAT].cl_neg)
            pitch_angle = -15'(PITCH_LIMIT);
        else
            pitch_angle = pitch_raw[14:0];
    end

    assign pitch_clamped = cd_reg[CLAT].cl_pos || cd_reg[CLAT].cl_neg;
    assign done          = pitch_vld;

    a_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        (roll_vld == pitch_vld) && (yaw_vld == pitch_vld))
        else $error("CORDIC pipelines out of step");
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result without matching request");
    a_clamp_val: assert property (@(posedge clk) disable iff (!rst_n)
        done && pitch_clamped |->
            (pitch_angle == 15'(PITCH_LIMIT)) || (pitch_angle == -15'(PITCH_LIMIT)))
        else $error("clamped pitch not at +-90 degrees");
endmodule
`default_nettype wire

// ===== sim/qte_checker.sv =====
// Checker: predicts roll, pitch and yaw for each request and compares the results.
`timescale 1ns / 1ps
module qte_checker #(
    parameter int ANGLE_ITERATIONS = 16
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic signed [15:0] quat_w,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    input  logic               done,
    input  logic signed [15:0] roll_angle,
    input  logic signed [14:0] pitch_angle,
    input  logic signed [15:0] yaw_angle,
    input  logic               pitch_clamped,
    output int                 fail_count,
    output int                 pending
);
    localparam longint ONE_Q30 = 64'sd1 << 30;
    localparam longint DEG90   = 64'sd90 * 32768;
    localparam longint ANG_LIM = 23040;
    localparam longint PIT_LIM = 11520;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
        logic signed [15:0] yaw;
        logic               clamped;
    } angles_t;

    angles_t angle_fifo[$];

    // atan(2^-i) in 2^-15 degree
    function automatic longint atan_step(int i);
        longint t[24] = '{1474560, 870484, 459940, 233473, 117189, 58652, 29333,
                          14667, 7334, 3667, 1833, 917, 458, 229, 115, 57,
                          29, 14, 7, 4, 2, 1, 0, 0};
        return t[i];
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return longint'(res);
    endfunction

    // vectoring arctangent, result in 1/128 degree, clamped
    function automatic longint arctan2_deg(longint sy, longint cx, longint lim);
        longint acc;
        longint t;
        longint dx;
        longint dy;
        longint r;
        int     n;
        acc = 0;
        n = (ANGLE_ITERATIONS > 24) ? 24 : ANGLE_ITERATIONS;
        if (cx == 0 && sy == 0)
            return 0;
        if (cx < 0) begin
            t = cx;
            if (sy >= 0) begin
                cx = sy;  sy = -t; acc = DEG90;
            end else begin
                cx = -sy; sy = t;  acc = -DEG90;
            end
        end
        for (int i = 0; i < n; i++) begin
            dx = sy >>> i;
            dy = cx >>> i;
            if (sy > 0) begin
                cx += dx; sy -= dy; acc += atan_step(i);
            end else begin
                cx -= dx; sy += dy; acc -= atan_step(i);
            end
        end
        r = (acc + 128) >>> 8;
        if (r > lim)  r = lim;
        if (r < -lim) r = -lim;
        return r;
    endfunction

    function automatic angles_t predict_angles(longint w, longint x, longint y, longint z);
        angles_t a;
        longint  sr;
        longint  cr;
        longint  sw;
        longint  cw;
        longint  sp;
        longint  cp;
        sr = 2 * (w * x + y * z);
        cr = ONE_Q30 - 2 * (x * x + y * y);
        sw = 2 * (w * z + x * y);
        cw = ONE_Q30 - 2 * (y * y + z * z);
        sp = 2 * (w * y - z * x);
        a.roll = 16'(arctan2_deg(sr, cr, ANG_LIM));
        a.yaw  = 16'(arctan2_deg(sw, cw, ANG_LIM));
        a.clamped = 1'b0;
        if (sp >= ONE_Q30) begin
            a.pitch = 15'(PIT_LIM);
            a.clamped = 1'b1;
        end else if (sp <= -ONE_Q30) begin
            a.pitch = 15'(-PIT_LIM);
            a.clamped = 1'b1;
        end else begin
            cp = int_sqrt((64'd1 << 60) - longint'(sp * sp));
            a.pitch = 15'(arctan2_deg(sp, cp, PIT_LIM));
        end
        return a;
    endfunction

    initial begin
        fail_count = 0;
        pending = 0;
    end

    always @(posedge clk) begin
        angles_t e;
        if (rst_n) begin
            if (start && !busy)
                angle_fifo.push_back(predict_angles(quat_w, quat_x, quat_y, quat_z));
            if (done) begin
                if (angle_fifo.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("ERROR: unexpected result r=%0d p=%0d y=%0d f=%0d",
                                 roll_angle, pitch_angle, yaw_angle, pitch_clamped);
                end else begin
                    e = angle_fifo.pop_front();
                    if (e.roll !== roll_angle || e.pitch !== pitch_angle ||
                        e.yaw !== yaw_angle || e.clamped !== pitch_clamped) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("ERROR: angles exp r=%0d p=%0d y=%0d f=%0d, got r=%0d p=%0d y=%0d f=%0d",
                                     e.roll, e.pitch, e.yaw, e.clamped, roll_angle,
                                     pitch_angle, yaw_angle, pitch_clamped);
                    end
                end
            end
            pending = angle_fifo.size();
        end
    end
endmodule

// ===== sim/tb_top.sv =====
// Testbench top: drives quaternion requests into the unit and reports the verdict.
`timescale 1ns / 1ps
module tb_top;
    localparam int DRAIN_CYCLES = 80;
    localparam int STALL_LIMIT  = 5000;
    localparam int RAND_REQS    = 1880;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [15:0] quat_w = '0;
    logic signed [15:0] quat_x = '0;
    logic signed [15:0] quat_y = '0;
    logic signed [15:0] quat_z = '0;
    logic               done;
    logic signed [15:0] roll_angle;
    logic signed [14:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic               pitch_clamped;
    int                 fail_count;
    int                 pending;
    int                 idle_pct = 0;
    int                 quiet_cycles = 0;

    always #5 clk = ~clk;

    quaternion_to_euler_angles_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
        .done(done), .roll_angle(roll_angle), .pitch_angle(pitch_angle),
        .yaw_angle(yaw_angle), .pitch_clamped(pitch_clamped)
    );

    qte_checker chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
        .done(done), .roll_angle(roll_angle), .pitch_angle(pitch_angle),
        .yaw_angle(yaw_angle), .pitch_clamped(pitch_clamped),
        .fail_count(fail_count), .pending(pending)
    );

    // watchdog: cycles with no request taken and no result out
    always @(posedge clk) begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Present one request; returns in the time step of the accepting edge so the
    // next request (or start low) follows without a gap or a double take.
    task automatic send_quat(input logic [15:0] w, x, y, z);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start  <= 1'b1;
        quat_w <= w;
        quat_x <= x;
        quat_y <= y;
        quat_z <= z;
        do
            @(posedge clk);
        while (busy);
    endtask

    // random attitude, unit length within Q1.15 rounding
    task automatic send_unit_quat();
        real a, b, c, n;
        real q[4];
        a = $urandom_range(0, 62831) / 10000.0;
        b = $urandom_range(0, 62831) / 10000.0;
        c = $urandom_range(0, 31415) / 10000.0;
        q[0] = $cos(c) * $cos(a);
        q[1] = $cos(c) * $sin(a);
        q[2] = $sin(c) * $cos(b);
        q[3] = $sin(c) * $sin(b);
        n = 32767.0;
        send_quat(16'($rtoi(q[0] * n)), 16'($rtoi(q[1] * n)),
                  16'($rtoi(q[2] * n)), 16'($rtoi(q[3] * n)));
    endtask

    // close to gimbal lock: w and y near +-1/sqrt(2), x and z small
    task automatic send_gimbal_quat();
        logic [15:0] w, y;
        w = 16'(23170 + $urandom_range(0, 40) - 20);
        y = 16'(23170 + $urandom_range(0, 40) - 20);
        if ($urandom_range(1)) y = -y;
        if ($urandom_range(1)) w = -w;
        send_quat(w, 16'($urandom_range(0, 64) - 32), y, 16'($urandom_range(0, 64) - 32));
    endtask

    initial begin
        int sel;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: identity, half turns about each axis, zero and extreme inputs
        send_quat(16'sd32767, 0, 0, 0);
        send_quat(0, 16'sd32767, 0, 0);        // roll half turn: zero sine, cosine negative
        send_quat(0, 0, 16'sd32767, 0);
        send_quat(0, 0, 0, 16'sd32767);        // yaw half turn
        send_quat(0, 0, 0, 0);                 // zero quaternion
        send_quat(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
        send_quat(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
        send_quat(16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768);
        send_quat(16'sd23170, 0, 16'sd23170, 0);   // pitch +90, right at the limit
        send_quat(16'sd23170, 0, -16'sd23170, 0);  // pitch -90
        send_quat(16'sd23171, 0, 16'sd23171, 0);   // sine past one: saturates
        send_quat(16'sd23171, 0, -16'sd23171, 0);
        send_quat(16'sd23169, 0, 16'sd23169, 0);   // just below saturation
        send_quat(16'sd32767, 0, 16'sd32767, 0);   // non-unit, deep saturation
        send_quat(0, 16'sd23170, 0, -16'sd23170);
        send_quat(16'sd23170, 16'sd23170, 0, 0);   // roll +90
        send_quat(16'sd23170, 0, 0, -16'sd23170);  // yaw -90
        send_quat(16'sd1, -16'sd1, 16'sd1, -16'sd1);
        send_quat(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384);
        send_quat(-16'sd16384, 16'sd16384, -16'sd16384, 16'sd16384);

        // random: four idling phases
        for (int i = 0; i < RAND_REQS; i++) begin
            case (i / (RAND_REQS / 4))
                0: idle_pct = 0;
                1: idle_pct = 69;
                2: idle_pct = 0;
                default: idle_pct = 13;
            endcase
            sel = $urandom_range(99);
            if (sel < 60)
                send_unit_quat();
            else if (sel < 80)
                send_gimbal_quat();
            else
                send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        end
        start <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
